FILE: src/cbc_pkg.sv
// ----------------------------------------------------------------------------
// cbc_pkg
// Types and constants shared by the cartridge bank controller modules.
// ----------------------------------------------------------------------------
package cbc_pkg;

  // Default size of the banked external RAM in bytes
  localparam int unsigned RAM_BYTES_DEFAULT = 32768;

  // Offset into bank space: two bank bits over a 13-bit window offset
  localparam int unsigned WIN_W    = 13;
  localparam int unsigned OFFSET_W = 15;

  // Access codes
  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // Address map
  localparam logic [15:0] MAP_RAM_EN_LAST   = 16'h1FFF;
  localparam logic [15:0] MAP_ROM_BANK_LAST = 16'h3FFF;
  localparam logic [15:0] MAP_RAM_BANK_LAST = 16'h5FFF;
  localparam logic [15:0] MAP_LATCH_LAST    = 16'h7FFF;
  localparam logic [15:0] RAM_WIN_FIRST     = 16'hA000;
  localparam logic [15:0] RAM_WIN_LAST      = 16'hBFFF;

  // Control register values
  localparam logic [3:0] RAM_EN_KEY     = 4'hA;
  localparam logic [6:0] ROM_BANK_MASK  = 7'h7F;
  localparam logic [6:0] ROM_BANK_RESET = 7'h01;
  localparam logic [7:0] RAM_BANK_LAST  = 8'h03;
  localparam logic [7:0] CLK_BANK_FIRST = 8'h08;
  localparam logic [7:0] CLK_BANK_LAST  = 8'h0C;
  localparam logic [7:0] OPEN_BUS       = 8'hFF;

  // Configuration register indexes
  typedef enum logic [7:0] {
    CFG_RAM_PRESENT   = 8'd0,
    CFG_CLOCK_PRESENT = 8'd1
  } cfg_index_t;

  // One bus access
  typedef struct packed {
    logic        operation;
    logic [15:0] address;
    logic [7:0]  write_data;
  } req_t;

  // One result
  typedef struct packed {
    logic [7:0] read_data;
    logic [6:0] rom_bank_out;
    logic [7:0] ram_bank_out;
    logic       ram_enable_out;
  } rsp_t;

  // Decode of one access against the current control state
  typedef struct packed {
    logic                ram_enable_next;
    logic [6:0]          rom_bank_next;
    logic [7:0]          ram_bank_next;
    logic                ram_read;
    logic                ram_write;
    logic [OFFSET_W-1:0] offset;
  } dec_t;

endpackage

FILE: src/cbc_decode.sv
// ----------------------------------------------------------------------------
// cbc_decode
// Address decode of one access: control register updates and RAM mapping.
// ----------------------------------------------------------------------------
module cbc_decode import cbc_pkg::*; #(
  parameter int unsigned RAM_BYTES = RAM_BYTES_DEFAULT
) (
  input  req_t       req,
  input  logic       ram_present,
  input  logic       ram_enable,
  input  logic [6:0] rom_page,
  input  logic [7:0] ram_bank,
  output dec_t       dec
);

  logic                in_window;
  logic                ram_mapped;
  logic [OFFSET_W-1:0] offset;
  logic [6:0]          rom_masked;

  // Map the RAM window onto the selected bank
  assign in_window  = (req.address >= RAM_WIN_FIRST) && (req.address <= RAM_WIN_LAST);
  assign offset     = {ram_bank[1:0], req.address[WIN_W-1:0]};
  assign ram_mapped = in_window && ram_present && ram_enable
                      && (ram_bank <= RAM_BANK_LAST)
                      && (32'(offset) < RAM_BYTES);
  assign rom_masked = req.write_data[6:0] & ROM_BANK_MASK;

  // Control writes below the RAM window, RAM access inside it
  always_comb begin
    dec.ram_enable_next = ram_enable;
    dec.rom_bank_next   = rom_page;
    dec.ram_bank_next   = ram_bank;
    dec.ram_read        = (req.operation == OP_READ) && ram_mapped;
    dec.ram_write       = (req.operation == OP_WRITE) && ram_mapped;
    dec.offset          = offset;
    if (req.operation == OP_WRITE) begin
      priority if (req.address <= MAP_RAM_EN_LAST) begin
        dec.ram_enable_next = (req.write_data[3:0] == RAM_EN_KEY);
      end else if (req.address <= MAP_ROM_BANK_LAST) begin
        dec.rom_bank_next = (rom_masked == 7'd0) ? ROM_BANK_RESET : rom_masked;
      end else if (req.address <= MAP_RAM_BANK_LAST) begin
        dec.ram_bank_next = req.write_data;
      end else begin
        // clock latch and everything above: no control effect
      end
    end
  end

endmodule

FILE: src/cartridge_bank_controller_core.sv
// ----------------------------------------------------------------------------
// cartridge_bank_controller_core
// Bus-side bank controller: control registers, banked external RAM and
// a two-stage result path.
// ----------------------------------------------------------------------------
// The controller takes one bus access per clock unless the request side
// stalls, and returns one result for each: the RAM stage decodes the access,
// updates the bank registers and reads or writes the RAM (whose read data is
// registered), and the output register then holds the result. Results
// show the bank state after the access. A stalled result holds in the output
// register while the next access is still accepted into the RAM stage; the
// request side stalls only when both stages are full. Configuration writes
// are always taken (ready held high). RAM contents are not cleared by reset.
module cartridge_bank_controller_core import cbc_pkg::*; #(
  parameter int unsigned RAM_BYTES = RAM_BYTES_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_stall,
  input  req_t       req,
  output logic       rsp_valid,
  input  logic       rsp_stall,
  output rsp_t       rsp,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_index,
  input  logic [7:0] cfg_data
);

  localparam int unsigned ADDR_W = $clog2(RAM_BYTES);

  // Configuration and control state
  logic       ram_present;
  logic       clock_present;
  logic       ram_enable;
  logic [6:0] rom_page;
  logic [7:0] ram_bank;

  // RAM stage
  logic       s1_valid;
  logic       s1_hit;
  logic [7:0] s1_rdata;
  logic [6:0] s1_rom_bank;
  logic [7:0] s1_ram_bank;
  logic       s1_ram_enable;

  logic       accept;
  logic       s1_adv;
  dec_t       dec;

  logic [7:0] ram_mem [RAM_BYTES];

  // Configuration port
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ram_present   <= 1'b0;
      clock_present <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_RAM_PRESENT:   ram_present   <= cfg_data[0];
        CFG_CLOCK_PRESENT: clock_present <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Handshake: the RAM stage drains when the output register is free
  assign s1_adv    = s1_valid && (!rsp_valid || !rsp_stall);
  assign req_stall = s1_valid && !s1_adv;
  assign accept    = req_valid && !req_stall;

  cbc_decode #(
    .RAM_BYTES (RAM_BYTES)
  ) u_decode (
    .req         (req),
    .ram_present (ram_present),
    .ram_enable  (ram_enable),
    .rom_page    (rom_page),
    .ram_bank    (ram_bank),
    .dec         (dec)
  );

  // Update control registers on each accepted request
  always_ff @(posedge clk) begin
    if (rst) begin
      ram_enable <= 1'b0;
      rom_page   <= ROM_BANK_RESET;
      ram_bank   <= 8'd0;
    end else if (accept) begin
      ram_enable <= dec.ram_enable_next;
      rom_page   <= dec.rom_bank_next;
      ram_bank   <= dec.ram_bank_next;
    end
  end

  // Banked RAM: one access per accepted request, read data registered
  always_ff @(posedge clk) begin
    if (accept) begin
      if (dec.ram_write) begin
        ram_mem[dec.offset[ADDR_W-1:0]] <= req.write_data;
      end
      s1_rdata <= ram_mem[dec.offset[ADDR_W-1:0]];
    end
  end

  // RAM stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  // RAM stage payload
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_hit        <= dec.ram_read;
      s1_rom_bank   <= dec.rom_bank_next;
      s1_ram_bank   <= dec.ram_bank_next;
      s1_ram_enable <= dec.ram_enable_next;
    end
  end

  // Output register control
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (s1_adv) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      rsp.read_data      <= s1_hit ? s1_rdata : OPEN_BUS;
      rsp.rom_bank_out   <= s1_rom_bank;
      rsp.ram_bank_out   <= s1_ram_bank;
      rsp.ram_enable_out <= s1_ram_enable;
    end
  end

  // Selected ROM bank is never zero
  a_rom_bank_nonzero: assert property (@(posedge clk) disable iff (rst)
    rom_page != 7'd0)
    else $error("ROM bank register holds zero");

  // Request side stalls only when both stages are full and the output waits
  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    req_stall |-> (rsp_valid && rsp_stall))
    else $error("request stalled with room in the pipeline");

  // A write never returns RAM data
  a_write_no_hit: assert property (@(posedge clk) disable iff (rst)
    (accept && req.operation == OP_WRITE) |=> !s1_hit)
    else $error("write access marked as RAM read");

  // Clock bank reads never reach the RAM
  a_clock_bank_open: assert property (@(posedge clk) disable iff (rst)
    (accept && clock_present && req.operation == OP_READ
     && ram_bank >= CLK_BANK_FIRST && ram_bank <= CLK_BANK_LAST)
    |=> (s1_valid && !s1_hit))
    else $error("clock bank read mapped onto RAM");

  // A stage that cannot drain keeps its request
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_adv) |=> s1_valid)
    else $error("RAM stage lost a stalled request");

endmodule
